// File: src/assert_macros.svh
// Assertion macros shared by the binary heap RTL.
// Assertions are compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Same-cycle implication outside reset
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`endif
`endif

// File: src/bhip_pkg.sv
// Types and constants for the binary heap insert/peek block.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none
package bhip_pkg;

   localparam int KEY_W   = 16;
   localparam int GRADE_W = 8;
   localparam int TAG_W   = 16;
   localparam int COUNT_W = 5;

   // Input action codes
   localparam logic ACTION_INSERT = 1'b0;
   localparam logic ACTION_CLEAR  = 1'b1;

   // Heap order codes for heap_mode
   localparam logic MODE_MIN = 1'b0;
   localparam logic MODE_MAX = 1'b1;

   // Register index of heap_mode
   localparam logic REG_HEAP_MODE = 1'b0;

   typedef struct packed {
      logic                      action;
      logic signed [KEY_W-1:0]   new_key;
      logic [GRADE_W-1:0]        new_grade;
      logic [TAG_W-1:0]          record_tag;
   } req_type;

   typedef struct packed {
      logic signed [KEY_W-1:0]   top_key;
      logic [GRADE_W-1:0]        top_grade;
      logic [TAG_W-1:0]          top_tag;
      logic [COUNT_W-1:0]        entry_count;
      logic                      heap_empty;
      logic                      insert_dropped;
   } rsp_type;

   // One stored heap record
   typedef struct packed {
      logic signed [KEY_W-1:0]   key;
      logic [GRADE_W-1:0]        grade;
      logic [TAG_W-1:0]          tag;
   } rec_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_FINISH,
      ST_DONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic rd_parent;
      logic cmp;
      logic finish;
      logic load_rsp;
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_clear;
      logic is_full;
      logic fill_zero;
      logic par_is_root;
   } dp_status_type;

endpackage
`default_nettype wire

// File: src/bhip_ctrl.sv
// Sequencing state machine for insert and sift-up of the binary heap.
// Depends on bhip_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module bhip_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   input  wire bhip_pkg::dp_status_type status,
   output bhip_pkg::ctl_cmd_type        cmd
);

   bhip_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // State and output-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bhip_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         bhip_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.is_clear || status.is_full) begin
                  state_in = bhip_pkg::ST_DONE;
               end else if (status.fill_zero) begin
                  state_in = bhip_pkg::ST_FINISH;
               end else begin
                  state_in = bhip_pkg::ST_READ;
               end
            end
         end
         bhip_pkg::ST_READ: begin
            cmd.rd_parent = 1'b1;
            state_in      = bhip_pkg::ST_CMP;
         end
         bhip_pkg::ST_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = status.par_is_root ? bhip_pkg::ST_FINISH : bhip_pkg::ST_READ;
         end
         bhip_pkg::ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = bhip_pkg::ST_DONE;
         end
         bhip_pkg::ST_DONE: begin
            // Load the output register once it is free or being drained
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               state_in     = bhip_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bhip_pkg::ST_IDLE;
         end
      endcase
   end

   // Hold the result until taken
   assign rsp_valid_in = cmd.load_rsp | (rsp_valid_ff & rsp_stall);
   assign rsp_valid    = rsp_valid_ff;
   assign req_stall    = (state_ff != bhip_pkg::ST_IDLE);

   `ASSERT_IMPL(a_cmp_after_read, clock, reset, state_ff == bhip_pkg::ST_CMP,
      $past(state_ff) == bhip_pkg::ST_READ)
   `ASSERT_IMPL(a_load_frees_slot, clock, reset, cmd.load_rsp,
      !rsp_valid_ff || !rsp_stall)

endmodule
`default_nettype wire

// File: src/bhip_dp.sv
// Heap storage, sift-up datapath, count and output register.
// Depends on bhip_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module bhip_dp #(
   parameter int CAPACITY = 31
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire bhip_pkg::ctl_cmd_type  cmd,
   input  wire bhip_pkg::req_type      req_data,
   input  wire logic                   heap_mode,
   output bhip_pkg::dp_status_type     status,
   output bhip_pkg::rsp_type           rsp_data
);

   localparam int CW = $clog2(CAPACITY + 1);

   bhip_pkg::rec_type heap_store_ff [CAPACITY+1];

   logic [CW-1:0]       fill_ff, fill_in;
   logic [CW-1:0]       pos_ff, pos_in;
   bhip_pkg::rec_type   cur_ff, cur_in;
   bhip_pkg::rec_type   root_ff, root_in;
   bhip_pkg::rec_type   rd_data_ff;
   logic                dropped_ff, dropped_in;
   bhip_pkg::rsp_type   rsp_ff, rsp_in;

   logic                mem_we;
   logic [CW-1:0]       wr_addr;
   bhip_pkg::rec_type   wr_data;
   logic [CW-1:0]       rd_addr;
   logic                swap;
   logic [CW+4:0]       fill_wide;

   // Status toward the controller
   assign status.is_clear    = (req_data.action == bhip_pkg::ACTION_CLEAR);
   assign status.is_full     = (fill_ff >= CW'(CAPACITY));
   assign status.fill_zero   = (fill_ff == '0);
   assign status.par_is_root = ((pos_ff >> 1) == CW'(1));

   assign rd_addr = pos_ff >> 1;

   // Parent strictly out of order for the current mode
   always_comb begin
      if (heap_mode == bhip_pkg::MODE_MAX) begin
         swap = (rd_data_ff.key < cur_ff.key);
      end else begin
         swap = (rd_data_ff.key > cur_ff.key);
      end
   end

   // Next values for count, position, carried record and root
   always_comb begin
      fill_in    = fill_ff;
      pos_in     = pos_ff;
      cur_in     = cur_ff;
      root_in    = root_ff;
      dropped_in = dropped_ff;
      mem_we     = 1'b0;
      wr_addr    = pos_ff;
      wr_data    = cur_ff;
      if (cmd.accept) begin
         dropped_in = !status.is_clear && status.is_full;
         if (status.is_clear) begin
            fill_in = '0;
         end else if (!status.is_full) begin
            fill_in    = fill_ff + CW'(1);
            pos_in     = fill_ff + CW'(1);
            cur_in.key   = req_data.new_key;
            cur_in.grade = req_data.new_grade;
            cur_in.tag   = req_data.record_tag;
         end
      end
      if (cmd.cmp) begin
         // Leave the record that belongs lower in the heap order at pos, carry the other upward
         mem_we  = 1'b1;
         wr_addr = pos_ff;
         wr_data = swap ? rd_data_ff : cur_ff;
         cur_in  = swap ? cur_ff : rd_data_ff;
         pos_in  = pos_ff >> 1;
      end
      if (cmd.finish) begin
         mem_we  = 1'b1;
         wr_addr = CW'(1);
         wr_data = cur_ff;
         root_in = cur_ff;
      end
   end

   // Heap store: one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         heap_store_ff[wr_addr] <= wr_data;
      end
      if (cmd.rd_parent) begin
         rd_data_ff <= heap_store_ff[rd_addr];
      end
   end

   // Count register
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Working payload registers
   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      cur_ff     <= cur_in;
      root_ff    <= root_in;
      dropped_ff <= dropped_in;
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   // Build the result transaction
   assign fill_wide = {5'd0, fill_ff};
   always_comb begin
      rsp_in = '0;
      if (fill_ff != '0) begin
         rsp_in.top_key   = root_ff.key;
         rsp_in.top_grade = root_ff.grade;
         rsp_in.top_tag   = root_ff.tag;
      end
      rsp_in.entry_count    = fill_wide[4:0];
      rsp_in.heap_empty     = (fill_ff == '0);
      rsp_in.insert_dropped = dropped_ff;
   end

   assign rsp_data = rsp_ff;

   `ASSERT_PROP(a_fill_bound, clock, reset, fill_ff <= CW'(CAPACITY))
   `ASSERT_IMPL(a_no_slot_zero, clock, reset, mem_we, wr_addr != '0)

endmodule
`default_nettype wire

// File: src/binary_heap_insert_peek.sv
// Binary heap insert/peek: an insert is accepted, then reads and compares once
// per heap level climbed up to the root, then writes the root and loads the
// result; clear and refused inserts go from accept to the result load. One
// transaction is worked at a time, set by the read-compare-write loop of sift-up.
// A result may wait in the output register while the next transaction is worked.
// Synchronous reset empties the heap and sets max-heap order; no clearing pass.
`default_nettype none
module binary_heap_insert_peek #(
   parameter int CAPACITY = 31
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire bhip_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output bhip_pkg::rsp_type       rsp_data,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [2:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   bhip_pkg::ctl_cmd_type   cmd;
   bhip_pkg::dp_status_type status;
   logic                    heap_mode_ff, heap_mode_in;
   logic                    csr_wr;

   // Configuration register
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      heap_mode_in = heap_mode_ff;
      if (csr_wr && (csr_paddr[2] == bhip_pkg::REG_HEAP_MODE)) begin
         heap_mode_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_mode_ff <= bhip_pkg::MODE_MAX;
      end else begin
         heap_mode_ff <= heap_mode_in;
      end
   end

   // Register read-back
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == bhip_pkg::REG_HEAP_MODE) begin
         csr_prdata[0] = heap_mode_ff;
      end
   end

   bhip_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bhip_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .heap_mode (heap_mode_ff),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
